### hw/rtl/tlv_message_deframer_unit_defines.svh
// Assertion macros for the TLV message deframer checker.
// Depends on clk and arst_n being visible where the macros are used.
`ifndef TLV_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH
`define TLV_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define TLVD_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("tlvd assertion failed");

// next-cycle implication
`define TLVD_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("tlvd assertion failed");

`endif

### hw/rtl/tlvd_pkg.sv
// Shared types and constants for the TLV message deframer.
// No dependencies.
package tlvd_pkg;

	typedef enum logic [2:0] {
		KIND_MSG_HDR  = 3'd0,
		KIND_FLD_HDR  = 3'd1,
		KIND_PAYLOAD  = 3'd2,
		KIND_END      = 3'd3,
		KIND_TOO_MANY = 3'd4,
		KIND_TOO_LONG = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_FIELD   = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	// last byte position of the 4-byte message and field headers
	localparam logic [1:0] SUB_LAST = 2'd3;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  cmd;
		logic [3:0]  total;
		logic [2:0]  index;
		logic [15:0] tag;
		logic [9:0]  len;
		logic [7:0]  data;
		logic        last;
	} tlvd_event_t;

endpackage

### hw/rtl/tlvd_front.sv
// Front end: parses received bytes and classifies each into at most one event.
// Depends on tlvd_pkg.
module tlvd_front import tlvd_pkg::*; #(
	parameter int MAX_FIELDS   = 8,
	parameter int CLIP_BYTES   = 640,
	parameter int BUFFER_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [7:0]  rx_byte,
	output logic        ev_valid,
	output tlvd_event_t ev
);

	localparam int CLIP_W = $clog2(CLIP_BYTES + 1);
	localparam int MB_W   = $clog2(BUFFER_BYTES + 1);

	phase_t              phase_q, phase_d;
	logic [1:0]          sub_q, sub_d;
	logic [MB_W-1:0]     mb_q, mb_d;
	logic [7:0]          cmd_q, count_q, index_q;
	logic [15:0]         tag_q, rem_q;
	logic [CLIP_W-1:0]   off_q, clip_q;

	logic                too_long, sub_last, too_many, rem_zero, dec_zero, shown, final_fld;
	logic [15:0]         rem_full, rem_dec, clip_cur_w, clip_new_w;
	logic [CLIP_W-1:0]   clip_new;

	always_comb begin
		too_long   = mb_q >= MB_W'(BUFFER_BYTES);
		sub_last   = sub_q == SUB_LAST;
		too_many   = count_q > 8'(MAX_FIELDS);
		rem_full   = {rem_q[15:8], rx_byte};
		rem_zero   = rem_full == 16'd0;
		clip_new   = (rem_full < 16'(CLIP_BYTES)) ? CLIP_W'(rem_full) : CLIP_W'(CLIP_BYTES);
		rem_dec    = rem_q - 16'd1;
		dec_zero   = rem_dec == 16'd0;
		shown      = off_q < clip_q;
		final_fld  = (9'(index_q) + 9'd1) >= 9'(count_q);
		clip_cur_w = 16'(clip_q);
		clip_new_w = 16'(clip_new);
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		sub_d   = sub_q;
		mb_d    = mb_q;
		if (acc) begin
			if (too_long) begin
				phase_d = PH_HEADER;
				sub_d   = '0;
				mb_d    = '0;
			end else begin
				mb_d  = MB_W'(mb_q + 1'b1);
				sub_d = sub_q + 2'd1;
				unique case (phase_q)
					PH_HEADER: begin
						if (sub_last) begin
							if (!too_many && count_q != 8'd0)
								phase_d = PH_FIELD;
							else
								mb_d = '0;
						end
					end
					PH_FIELD: begin
						if (sub_last) begin
							if (!rem_zero) begin
								phase_d = PH_PAYLOAD;
							end else if (final_fld) begin
								phase_d = PH_HEADER;
								mb_d    = '0;
							end
						end
					end
					PH_PAYLOAD: begin
						sub_d = '0;
						if (dec_zero) begin
							if (final_fld) begin
								phase_d = PH_HEADER;
								mb_d    = '0;
							end else begin
								phase_d = PH_FIELD;
							end
						end
					end
					default: begin
						phase_d = PH_HEADER;
						sub_d   = '0;
						mb_d    = '0;
					end
				endcase
			end
		end
	end

	// event outputs
	always_comb begin
		ev_valid = 1'b0;
		ev.kind  = KIND_MSG_HDR;
		ev.cmd   = cmd_q;
		ev.total = count_q[3:0];
		ev.index = index_q[2:0];
		ev.tag   = tag_q;
		ev.len   = clip_cur_w[9:0];
		ev.data  = rx_byte;
		ev.last  = 1'b0;
		if (acc) begin
			if (too_long) begin
				ev_valid = 1'b1;
				ev.kind  = KIND_TOO_LONG;
				ev.last  = 1'b1;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (sub_last) begin
							ev_valid = 1'b1;
							if (too_many) begin
								ev.kind = KIND_TOO_MANY;
								ev.last = 1'b1;
							end else begin
								ev.kind = KIND_MSG_HDR;
								ev.last = count_q == 8'd0;
							end
						end
					end
					PH_FIELD: begin
						if (sub_last) begin
							ev_valid = 1'b1;
							ev.kind  = KIND_FLD_HDR;
							ev.len   = clip_new_w[9:0];
							ev.last  = rem_zero && final_fld;
						end
					end
					PH_PAYLOAD: begin
						if (shown) begin
							ev_valid = 1'b1;
							ev.kind  = KIND_PAYLOAD;
							ev.last  = dec_zero && final_fld;
						end else if (dec_zero && final_fld) begin
							ev_valid = 1'b1;
							ev.kind  = KIND_END;
							ev.last  = 1'b1;
						end
					end
					default: ev_valid = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			sub_q   <= '0;
			mb_q    <= '0;
		end else begin
			phase_q <= phase_d;
			sub_q   <= sub_d;
			mb_q    <= mb_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= '0;
			count_q <= '0;
			index_q <= '0;
			tag_q   <= '0;
			rem_q   <= '0;
			off_q   <= '0;
			clip_q  <= '0;
		end else if (acc && !too_long) begin
			case (phase_q)
				PH_HEADER: begin
					if (sub_q == 2'd1) cmd_q <= rx_byte;
					if (sub_q == 2'd2) count_q <= rx_byte;
					if (sub_last && !too_many) begin
						index_q <= '0;
						tag_q   <= '0;
						clip_q  <= '0;
					end
				end
				PH_FIELD: begin
					case (sub_q)
						2'd0: tag_q <= {rx_byte, 8'h00};
						2'd1: tag_q[7:0] <= rx_byte;
						2'd2: rem_q <= {rx_byte, 8'h00};
						default: begin
							rem_q  <= rem_full;
							clip_q <= clip_new;
							off_q  <= '0;
							if (rem_zero && !final_fld) index_q <= index_q + 8'd1;
						end
					endcase
				end
				PH_PAYLOAD: begin
					if (shown) off_q <= off_q + 1'b1;
					rem_q <= rem_dec;
					if (dec_zero && !final_fld) index_q <= index_q + 8'd1;
				end
				default: ;
			endcase
		end
	end

endmodule

### hw/rtl/tlvd_queue.sv
// Short event queue between the front parser and the back output stage.
// Depends on tlvd_pkg.
module tlvd_queue import tlvd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  tlvd_event_t wr_data,
	output logic        full,
	input  logic        rd_en,
	output logic        rd_valid,
	output tlvd_event_t rd_data
);

	tlvd_event_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0]     wp_q, rp_q;
	logic [Q_CW-1:0]     cnt_q;

	assign full     = cnt_q == Q_CW'(Q_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + Q_CW'(wr_en) - Q_CW'(rd_en);
		end
	end

endmodule

### hw/rtl/tlvd_back.sv
// Back end: takes events from the queue, clears fields by kind, holds the result.
// Depends on tlvd_pkg.
module tlvd_back import tlvd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  tlvd_event_t q_data,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  kind,
	output logic [7:0]  cmd_tag,
	output logic [3:0]  field_total,
	output logic [2:0]  field_index,
	output logic [15:0] field_tag,
	output logic [9:0]  field_length,
	output logic [7:0]  data_byte,
	output logic        last
);

	logic        valid_q;
	tlvd_event_t res_q, fmt;

	assign q_pop = q_valid && (!valid_q || pop);

	always_comb begin
		fmt = q_data;
		case (q_data.kind) inside
			KIND_FLD_HDR, KIND_PAYLOAD, KIND_END: ;
			default: begin
				fmt.index = '0;
				fmt.tag   = '0;
				fmt.len   = '0;
			end
		endcase
		if (q_data.kind != KIND_PAYLOAD) fmt.data = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (q_pop) valid_q <= 1'b1;
		else if (pop) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) res_q <= fmt;
	end

	assign empty        = !valid_q;
	assign kind         = res_q.kind;
	assign cmd_tag      = res_q.cmd;
	assign field_total  = res_q.total;
	assign field_index  = res_q.index;
	assign field_tag    = res_q.tag;
	assign field_length = res_q.len;
	assign data_byte    = res_q.data;
	assign last         = res_q.last;

endmodule

### hw/rtl/tlv_message_deframer_unit.sv
// Results pass through a 4-entry event queue and then the output register to the ports.
// Throughput: one byte per clock while full is low; the parser handles every byte in
// the cycle it arrives, and the queue plus the output register absorb output stalls.
// full rises only when the event queue holds four untaken events.
// Reset (arst_n low) returns the parser to header search and empties the queue.
module tlv_message_deframer_unit import tlvd_pkg::*; #(
	parameter int MAX_FIELDS   = 8,
	parameter int CLIP_BYTES   = 640,
	parameter int BUFFER_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [7:0]  cmd_tag,
	output logic [3:0]  field_total,
	output logic [2:0]  field_index,
	output logic [15:0] field_tag,
	output logic [9:0]  field_length,
	output logic [7:0]  data_byte,
	output logic        last
);

	logic        acc, ev_valid, q_valid, q_pop;
	tlvd_event_t ev, q_data;

	assign acc = push && !full;

	tlvd_front #(
		.MAX_FIELDS  (MAX_FIELDS),
		.CLIP_BYTES  (CLIP_BYTES),
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.rx_byte (rx_byte),
		.ev_valid(ev_valid),
		.ev      (ev)
	);

	tlvd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ev_valid),
		.wr_data (ev),
		.full    (full),
		.rd_en   (q_pop),
		.rd_valid(q_valid),
		.rd_data (q_data)
	);

	tlvd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.cmd_tag     (cmd_tag),
		.field_total (field_total),
		.field_index (field_index),
		.field_tag   (field_tag),
		.field_length(field_length),
		.data_byte   (data_byte),
		.last        (last)
	);

endmodule

### hw/rtl/tlvd_checker.sv
// Port-level checks for the TLV message deframer, bound to the top level.
// Depends on tlvd_pkg and tlv_message_deframer_unit_defines.svh.
`include "tlv_message_deframer_unit_defines.svh"

module tlvd_checker import tlvd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  kind,
	input logic [7:0]  cmd_tag,
	input logic [3:0]  field_total,
	input logic [2:0]  field_index,
	input logic [15:0] field_tag,
	input logic [9:0]  field_length,
	input logic [7:0]  data_byte,
	input logic        last
);

	logic [52:0] res_bits;
	logic        is_end, no_info, info_zero;

	assign res_bits  = {kind, cmd_tag, field_total, field_index, field_tag, field_length,
		data_byte, last};
	assign is_end    = kind == KIND_END || kind == KIND_TOO_MANY || kind == KIND_TOO_LONG;
	assign no_info   = kind == KIND_MSG_HDR || kind == KIND_TOO_MANY || kind == KIND_TOO_LONG;
	assign info_zero = field_index == 3'd0 && field_tag == 16'd0 && field_length == 10'd0;

	// a waiting transaction holds until taken
	`TLVD_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(res_bits))
	`TLVD_ASSERT_IMP(a_kind_range, !empty, kind <= KIND_TOO_LONG)
	`TLVD_ASSERT_IMP(a_end_last, !empty && is_end, last)
	`TLVD_ASSERT_IMP(a_data_zero, !empty && kind != KIND_PAYLOAD, data_byte == 8'd0)
	`TLVD_ASSERT_IMP(a_info_zero, !empty && no_info, info_zero)

endmodule

bind tlv_message_deframer_unit tlvd_checker u_tlvd_checker (.*);
